/* sv/two_species_traffic_automaton_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the two-species traffic automaton
// ---------------------------------------------------------------------------
`ifndef TWO_SPECIES_TRAFFIC_AUTOMATON_TOP_DEFINES_SVH
`define TWO_SPECIES_TRAFFIC_AUTOMATON_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define TSTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define TSTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TSTA_ASSERT(lbl, prop, msg)
`define TSTA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/tsta_pkg.sv */
// ---------------------------------------------------------------------------
// tsta_pkg
// Shared types, codes and the cell update rule of the traffic automaton.
// ---------------------------------------------------------------------------
package tsta_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // configuration register indexes
  localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_STEPS = 2'd2;

  localparam logic [8:0]  ROW_COUNT_RST = 9'd256;
  localparam logic [8:0]  COL_COUNT_RST = 9'd256;
  localparam logic [23:0] MAX_STEPS_RST = 24'hFFFFFF;

  // cell codes
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_EAST  = 2'd1;
  localparam logic [1:0] CELL_SOUTH = 2'd2;

  typedef struct packed {
    logic [8:0]  row_count;
    logic [8:0]  col_count;
    logic [23:0] max_steps;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LINE,
    ST_READ,
    ST_DRAIN,
    ST_TAIL1,
    ST_TAIL2,
    ST_NEXT,
    ST_DONE
  } seq_state_e;

  // new value of a cell from its left/upper, own and right/lower old values
  function automatic logic [1:0] cell_next(logic [1:0] left, logic [1:0] self,
                                           logic [1:0] right, logic [1:0] mov);
    logic [1:0] res;
    res = self;
    if (self == mov && right == CELL_EMPTY) begin
      res = CELL_EMPTY;
    end else if (self == CELL_EMPTY && left == mov) begin
      res = mov;
    end
    return res;
  endfunction

endpackage

/* sv/two_species_traffic_automaton_top.sv */
// Loading: one cell word per cycle while idle. The run starts after the last cell.
// Each line of the sweep is read through the grid memory's read port and
// written back through its write port; the result word is offered in the
// cycle after the last step.
// Reset clears control and configuration; grid memory is not cleared.
// ---------------------------------------------------------------------------
// two_species_traffic_automaton_top
// Two-species traffic automaton on a torus with a memory-held grid.
// ---------------------------------------------------------------------------
`include "two_species_traffic_automaton_top_defines.svh"

module two_species_traffic_automaton_top #(
  parameter int MAX_ROWS = tsta_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tsta_pkg::DEF_MAX_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cell_req_i,
  input  logic        last_cell_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] step_index_o,
  output logic        hit_limit_o
);
  import tsta_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  cfg_t cfg_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count <= ROW_COUNT_RST;
      cfg_q.col_count <= COL_COUNT_RST;
      cfg_q.max_steps <= MAX_STEPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW_COUNT: cfg_q.row_count <= cfg_data_i[8:0];
        CFG_COL_COUNT: cfg_q.col_count <= cfg_data_i[8:0];
        CFG_MAX_STEPS: cfg_q.max_steps <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsta_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_req_i   (cell_req_i),
    .last_cell_i  (last_cell_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_index_o (step_index_o),
    .hit_limit_o  (hit_limit_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tsta_grid_mem #(
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // no cell word taken while a result waits
  `TSTA_ASSERT(a_out_blocks_in, out_valid_o |-> in_stall_o, "input open with result pending")
  // the last cell starts a run, so the input closes next cycle
  `TSTA_ASSERT(a_run_starts, (in_valid_i && !in_stall_o && last_cell_i) |=> in_stall_o, "busy")
  // nothing is reported during reset
  `TSTA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result during reset")

endmodule

/* sv/tsta_grid_mem.sv */
// ---------------------------------------------------------------------------
// tsta_grid_mem
// Grid storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tsta_grid_mem #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [1:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [1:0]               rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tsta_seq.sv */
// ---------------------------------------------------------------------------
// tsta_seq
// Loads the grid, then sweeps it line by line: rows for the east phase,
// columns for the south phase, with a three-cell window on the read stream.
// ---------------------------------------------------------------------------
module tsta_seq #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  tsta_pkg::cfg_t                             cfg_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [1:0]                                 cell_req_i,
  input  logic                                       last_cell_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [23:0]                                step_index_o,
  output logic                                       hit_limit_o,
  output logic                                       mem_we_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       mem_waddr_o,
  output logic [1:0]                                 mem_wdata_o,
  output logic                                       mem_re_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       mem_raddr_o,
  input  logic [1:0]                                 mem_rdata_i
);
  import tsta_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int LW    = $clog2(MAXD + 1);

  seq_state_e state_q, state_d;
  logic [AW:0]    load_q, load_d;
  logic [23:0]    step_q, step_d;
  logic           moved_q, moved_d;
  logic           hit_q, hit_d;
  logic           east_q, east_d;
  logic [LW-1:0]  line_q, line_d;
  logic [AW-1:0]  base_q, base_d;
  logic [LW-1:0]  k_q, k_d;
  logic [AW-1:0]  addr_q, addr_d;

  // read pipe and window
  logic           rv_q;
  logic [LW-1:0]  rk_q;
  logic [AW-1:0]  ra_q, a1_q;
  logic [1:0]     p1_q, p2_q, old0_q, old1_q;

  logic [LW-1:0]   rows_eff, cols_eff, n_len, n_lines;
  logic [2*LW-1:0] cells;
  logic [23:0]     limit;
  logic [AW-1:0]   stride, line_step;
  logic [1:0]      mov, cell_in, nv, self_v;
  logic            upd;

  // clamp sizes to 1..max
  always_comb begin
    if (cfg_i.row_count == 9'd0) begin
      rows_eff = LW'(1);
    end else if (int'(cfg_i.row_count) > MAX_ROWS) begin
      rows_eff = LW'(MAX_ROWS);
    end else begin
      rows_eff = LW'(cfg_i.row_count);
    end
    if (cfg_i.col_count == 9'd0) begin
      cols_eff = LW'(1);
    end else if (int'(cfg_i.col_count) > MAX_COLS) begin
      cols_eff = LW'(MAX_COLS);
    end else begin
      cols_eff = LW'(cfg_i.col_count);
    end
  end

  assign cells     = (2*LW)'(rows_eff) * (2*LW)'(cols_eff);
  assign limit     = (cfg_i.max_steps == 24'd0) ? 24'd1 : cfg_i.max_steps;
  assign n_len     = east_q ? cols_eff : rows_eff;
  assign n_lines   = east_q ? rows_eff : cols_eff;
  assign stride    = east_q ? AW'(1) : AW'(cols_eff);
  assign line_step = east_q ? AW'(cols_eff) : AW'(1);
  assign mov       = east_q ? CELL_EAST : CELL_SOUTH;

  always_comb begin
    if (cell_req_i == CELL_EAST) begin
      cell_in = CELL_EAST;
    end else if (cell_req_i == CELL_SOUTH) begin
      cell_in = CELL_SOUTH;
    end else begin
      cell_in = CELL_EMPTY;
    end
  end

  // write port: load, streamed updates, then the two wrap cells
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = CELL_EMPTY;
    upd         = 1'b0;
    self_v      = CELL_EMPTY;
    nv          = CELL_EMPTY;
    if (state_q == ST_IDLE) begin
      if (in_valid_i && ((2*LW)'(load_q) < cells)) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = load_q[AW-1:0];
        mem_wdata_o = cell_in;
      end
    end else if (rv_q && rk_q >= LW'(2)) begin
      upd         = 1'b1;
      self_v      = p1_q;
      nv          = cell_next(p2_q, p1_q, mem_rdata_i, mov);
      mem_waddr_o = a1_q;
    end else if (state_q == ST_TAIL1 && n_len > LW'(1)) begin
      upd         = 1'b1;
      self_v      = p1_q;
      nv          = cell_next(p2_q, p1_q, old0_q, mov);
      mem_waddr_o = a1_q;
    end else if (state_q == ST_TAIL2 && n_len > LW'(1)) begin
      upd         = 1'b1;
      self_v      = old0_q;
      nv          = cell_next(p1_q, old0_q, old1_q, mov);
      mem_waddr_o = base_q;
    end
    if (upd) begin
      mem_we_o    = 1'b1;
      mem_wdata_o = nv;
    end
  end

  assign mem_re_o    = (state_q == ST_READ);
  assign mem_raddr_o = addr_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    step_d  = step_q;
    moved_d = moved_q;
    hit_d   = hit_q;
    east_d  = east_q;
    line_d  = line_q;
    base_d  = base_q;
    k_d     = k_q;
    addr_d  = addr_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    if (upd && nv != self_v) begin
      moved_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (last_cell_i) begin
            load_d  = '0;
            step_d  = '0;
            state_d = ST_START;
          end else if (int'(load_q) < DEPTH) begin
            load_d = load_q + (AW+1)'(1);
          end
        end
      end
      ST_START: begin
        step_d  = step_q + 24'd1;
        moved_d = 1'b0;
        east_d  = 1'b1;
        line_d  = '0;
        base_d  = '0;
        state_d = ST_LINE;
      end
      ST_LINE: begin
        k_d     = '0;
        addr_d  = base_q;
        state_d = ST_READ;
      end
      ST_READ: begin
        k_d    = k_q + LW'(1);
        addr_d = addr_q + stride;
        if (k_q == n_len - LW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_TAIL1;
      ST_TAIL1: state_d = ST_TAIL2;
      ST_TAIL2: state_d = ST_NEXT;
      ST_NEXT: begin
        if (line_q == n_lines - LW'(1)) begin
          if (east_q) begin
            east_d  = 1'b0;
            line_d  = '0;
            base_d  = '0;
            state_d = ST_LINE;
          end else if (!moved_q) begin
            hit_d   = 1'b0;
            state_d = ST_DONE;
          end else if (step_q >= limit) begin
            hit_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_START;
          end
        end else begin
          line_d  = line_q + LW'(1);
          base_d  = base_q + line_step;
          state_d = ST_LINE;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      load_q  <= '0;
      step_q  <= '0;
      moved_q <= 1'b0;
      hit_q   <= 1'b0;
      east_q  <= 1'b1;
      line_q  <= '0;
      base_q  <= '0;
      k_q     <= '0;
      addr_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      step_q  <= step_d;
      moved_q <= moved_d;
      hit_q   <= hit_d;
      east_q  <= east_d;
      line_q  <= line_d;
      base_q  <= base_d;
      k_q     <= k_d;
      addr_q  <= addr_d;
      rv_q    <= (state_q == ST_READ);
    end
  end

  // window over the read stream; first two cells kept for the wrap
  always_ff @(posedge clk_i) begin
    rk_q <= k_q;
    ra_q <= addr_q;
    if (rv_q) begin
      if (rk_q == LW'(0)) begin
        old0_q <= mem_rdata_i;
      end
      if (rk_q == LW'(1)) begin
        old1_q <= mem_rdata_i;
      end
      p2_q <= p1_q;
      p1_q <= mem_rdata_i;
      a1_q <= ra_q;
    end
  end

  assign step_index_o = step_q;
  assign hit_limit_o  = hit_q;

endmodule

/* tb/sv/tsta_checker.sv */
// ---------------------------------------------------------------------------
// tsta_checker
// Watches the register, cell and result channels of the traffic automaton,
// keeps its own copy of the grid, runs the automaton for every loaded grid
// and compares each result word with the oldest expected one.
// ---------------------------------------------------------------------------
module tsta_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cell_req_i,
  input  logic        last_cell_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [23:0] step_index_i,
  input  logic        hit_limit_i,
  output int          pending_o,
  output int          err_cnt_o
);
  import tsta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;

  typedef struct {
    logic [23:0] step_index;
    logic        hit_limit;
  } settle_t;

  // shadow of the block's state
  logic [1:0]  grid_mem [GRID_DEPTH];
  logic [8:0]  row_reg;
  logic [8:0]  col_reg;
  logic [23:0] step_lim_reg;
  int          load_addr;
  settle_t     settle_q[$];

  function automatic int clamp_dim(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic report_err(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt_o++;
  endtask

  // run the automaton until it settles or hits the step limit
  task automatic run_traffic(output settle_t res);
    int          rows;
    int          cols;
    logic [23:0] step_cnt;
    logic [23:0] lim;
    bit          moved;
    logic [1:0]  line [DEF_MAX_ROWS];
    int          nx;
    int          pv;
    rows = clamp_dim(row_reg, DEF_MAX_ROWS);
    cols = clamp_dim(col_reg, DEF_MAX_COLS);
    lim = (step_lim_reg == 0) ? 24'd1 : step_lim_reg;
    step_cnt = 0;
    forever begin
      step_cnt++;
      moved = 0;
      // east phase, all rows at once from the old row values
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) line[c] = grid_mem[r*cols + c];
        for (int c = 0; c < cols; c++) begin
          nx = (c + 1) % cols;
          pv = (c + cols - 1) % cols;
          if (line[c] == CELL_EAST && line[nx] == CELL_EMPTY) begin
            grid_mem[r*cols + c] = CELL_EMPTY;
            moved = 1;
          end else if (line[c] == CELL_EMPTY && line[pv] == CELL_EAST) begin
            grid_mem[r*cols + c] = CELL_EAST;
          end
        end
      end
      // south phase on the grid left by the east phase
      for (int c = 0; c < cols; c++) begin
        for (int r = 0; r < rows; r++) line[r] = grid_mem[r*cols + c];
        for (int r = 0; r < rows; r++) begin
          nx = (r + 1) % rows;
          pv = (r + rows - 1) % rows;
          if (line[r] == CELL_SOUTH && line[nx] == CELL_EMPTY) begin
            grid_mem[r*cols + c] = CELL_EMPTY;
            moved = 1;
          end else if (line[r] == CELL_EMPTY && line[pv] == CELL_SOUTH) begin
            grid_mem[r*cols + c] = CELL_SOUTH;
          end
        end
      end
      if (!moved) begin
        res.step_index = step_cnt;
        res.hit_limit  = 1'b0;
        break;
      end
      if (step_cnt >= lim) begin
        res.step_index = step_cnt;
        res.hit_limit  = 1'b1;
        break;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    settle_t exp_w;
    settle_t got_w;
    int      n_cells;
    if (!rst_ni) begin
      row_reg      = ROW_COUNT_RST;
      col_reg      = COL_COUNT_RST;
      step_lim_reg = MAX_STEPS_RST;
      load_addr    = 0;
      settle_q.delete();
      err_cnt_o    = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROW_COUNT: row_reg = cfg_data_i[8:0];
          CFG_COL_COUNT: col_reg = cfg_data_i[8:0];
          CFG_MAX_STEPS: step_lim_reg = cfg_data_i;
          default: ;
        endcase
      end
      // cell words
      if (in_valid_i && !in_stall_i) begin
        n_cells = clamp_dim(row_reg, DEF_MAX_ROWS) * clamp_dim(col_reg, DEF_MAX_COLS);
        if (load_addr < n_cells && load_addr < GRID_DEPTH)
          grid_mem[load_addr] = (cell_req_i == CELL_EAST || cell_req_i == CELL_SOUTH) ?
                                cell_req_i : CELL_EMPTY;
        if (load_addr < GRID_DEPTH) load_addr++;
        if (last_cell_i) begin
          load_addr = 0;
          run_traffic(exp_w);
          settle_q = {settle_q, exp_w};
        end
      end
      // result words
      if (out_valid_i && !out_stall_i) begin
        got_w.step_index = step_index_i;
        got_w.hit_limit  = hit_limit_i;
        if (settle_q.size() == 0) begin
          report_err($sformatf("unexpected result step_index=%0d hit_limit=%0b",
                               got_w.step_index, got_w.hit_limit));
        end else begin
          exp_w = settle_q.pop_front();
          if (got_w.step_index !== exp_w.step_index)
            report_err($sformatf("step_index got %0d want %0d",
                                 got_w.step_index, exp_w.step_index));
          if (got_w.hit_limit !== exp_w.hit_limit)
            report_err($sformatf("hit_limit got %0b want %0b",
                                 got_w.hit_limit, exp_w.hit_limit));
        end
      end
    end
    pending_o = settle_q.size();
  end

endmodule

/* tb/sv/tb_two_species_traffic_automaton_top.sv */
// ---------------------------------------------------------------------------
// tb_two_species_traffic_automaton_top
// Loads grids into the traffic automaton under random gaps and result stalls,
// moving through several size and step-limit settings; the checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
module tb_two_species_traffic_automaton_top;
  import tsta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // spare cell code, stored as empty
  localparam logic [1:0] CELL_SPARE = 2'd3;
  localparam int N_ITEMS = 900;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cell_req_i;
  logic        last_cell_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [23:0] step_index_o;
  logic        hit_limit_o;
  int          pending;
  int          err_cnt;

  // generator-side shadow of the grid size and written prefix
  int cur_rows;
  int cur_cols;
  int written_hi;
  int cells_sent;
  int runs_sent;
  int cfg_writes;
  bit stall_quiet;

  two_species_traffic_automaton_top u_top (.*);

  tsta_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cell_req_i, .last_cell_i,
    .out_valid_i(out_valid_o), .out_stall_i, .step_index_i(step_index_o),
    .hit_limit_i(hit_limit_o), .pending_o(pending), .err_cnt_o(err_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("two_species_traffic_automaton_top test failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result stalls, with quiet stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_quiet = ~stall_quiet;
    out_stall_i = stall_quiet ? 1'b0 : ($urandom_range(0, 99) < 35);
  end

  function automatic int clamp_dim(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
    bit rdy;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    forever begin
      #1 rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
    if (idx == CFG_ROW_COUNT) cur_rows = clamp_dim(data[8:0], DEF_MAX_ROWS);
    if (idx == CFG_COL_COUNT) cur_cols = clamp_dim(data[8:0], DEF_MAX_COLS);
  endtask

  // one cell word; returns at a falling edge after acceptance
  task automatic send_cell(input logic [1:0] code, input logic last);
    bit stalled;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    cell_req_i  = code;
    last_cell_i = last;
    forever begin
      #1 stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cells_sent++;
  endtask

  // load n random cells, the last one starting the run
  task automatic load_grid(input int n);
    int n_cells;
    n_cells = cur_rows * cur_cols;
    for (int i = 0; i < n; i++) send_cell(2'($urandom_range(0, 3)), i == n - 1);
    in_valid_i = 1'b0;
    if (n > written_hi && written_hi < n_cells) written_hi = (n < n_cells) ? n : n_cells;
    runs_sent++;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int n_cells;
    int n;
    int r;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROW_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cell_req_i = CELL_EMPTY;
    last_cell_i = 1'b0;
    cur_rows = DEF_MAX_ROWS;
    cur_cols = DEF_MAX_COLS;
    written_hi = 0;
    cells_sent = 0;
    runs_sent = 0;
    cfg_writes = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty grid with the spare code, largest step limit: settles at once
    cfg_write(CFG_ROW_COUNT, 24'd2);
    cfg_write(CFG_COL_COUNT, 24'd3);
    cfg_write(CFG_MAX_STEPS, MAX_STEPS_RST);
    for (int i = 0; i < 6; i++) send_cell(CELL_SPARE, i == 5);
    in_valid_i = 1'b0;
    written_hi = 6;
    runs_sent++;
    wait_idle();

    // single row, zero limit acts as one step
    cfg_write(CFG_ROW_COUNT, 24'd1);
    cfg_write(CFG_COL_COUNT, 24'd4);
    cfg_write(CFG_MAX_STEPS, 24'd0);
    cfg_write(CFG_UNUSED, 24'hFFFFFF);
    send_cell(CELL_EAST, 1'b0);
    send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_SOUTH, 1'b0);
    send_cell(CELL_SPARE, 1'b1);
    in_valid_i = 1'b0;
    runs_sent++;
    wait_idle();

    // single column jam: nothing can move
    cfg_write(CFG_ROW_COUNT, 24'd3);
    cfg_write(CFG_COL_COUNT, 24'd1);
    cfg_write(CFG_MAX_STEPS, MAX_STEPS_RST);
    send_cell(CELL_EAST, 1'b0);
    send_cell(CELL_SOUTH, 1'b0);
    send_cell(CELL_SOUTH, 1'b1);
    in_valid_i = 1'b0;
    runs_sent++;
    wait_idle();

    // oversize rows saturate to the maximum, extra cells dropped
    cfg_write(CFG_ROW_COUNT, 24'h1FF);
    cfg_write(CFG_COL_COUNT, 24'd0);
    cfg_write(CFG_MAX_STEPS, 24'd2);
    load_grid(cur_rows * cur_cols + 2);
    wait_idle();
    // full-width single row
    cfg_write(CFG_ROW_COUNT, 24'd1);
    cfg_write(CFG_COL_COUNT, 24'd256);
    cfg_write(CFG_MAX_STEPS, 24'd3);
    load_grid(cur_rows * cur_cols);
    wait_idle();

    // random phases of small grids
    while (cells_sent < N_ITEMS) begin
      r = $urandom_range(0, 19);
      cfg_write(CFG_ROW_COUNT, (r == 0) ? 24'd0 : 24'($urandom_range(1, 8)));
      cfg_write(CFG_COL_COUNT, (r == 1) ? 24'd0 : 24'($urandom_range(1, 8)));
      r = $urandom_range(0, 9);
      cfg_write(CFG_MAX_STEPS, (r == 0) ? 24'd0 :
                (r < 5) ? 24'($urandom_range(1, 8)) : 24'($urandom_range(9, 40)));
      repeat ($urandom_range(2, 4)) begin
        n_cells = cur_rows * cur_cols;
        n = n_cells;
        r = $urandom_range(0, 9);
        if (r == 0) n = n_cells + $urandom_range(1, 3);
        else if (r == 1 && written_hi >= n_cells) n = $urandom_range(1, n_cells);
        load_grid(n);
        if ($urandom_range(0, 2) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(negedge clk_i);
    $display("covered %0d cell words in %0d grid runs with %0d register writes",
             cells_sent, runs_sent, cfg_writes);
    if (err_cnt == 0) begin
      $display("two_species_traffic_automaton_top test passed");
    end else begin
      $display("two_species_traffic_automaton_top test failed");
    end
    $finish;
  end

endmodule

/* two_species_traffic_automaton_top.f */
+incdir+sv
sv/tsta_pkg.sv
sv/tsta_grid_mem.sv
sv/tsta_seq.sv
sv/two_species_traffic_automaton_top.sv
tb/sv/tsta_checker.sv
tb/sv/tb_two_species_traffic_automaton_top.sv
